// ===== rtl/core/aoc_pkg.sv =====
package aoc_pkg;

    // Width of every coordinate, depth and contact field on the ports.
    localparam int FIELD_W = 32;

    // Number of axes handled side by side.
    localparam int NUM_AXES = 3;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

endpackage

// ===== rtl/core/aoc_axis.sv =====
module aoc_axis #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic [aoc_pkg::FIELD_W-1:0]       i_qmin,
    input  logic [aoc_pkg::FIELD_W-1:0]       i_qmax,
    input  logic [aoc_pkg::FIELD_W-1:0]       i_omin,
    input  logic [aoc_pkg::FIELD_W-1:0]       i_omax,
    output logic signed [COORD_WIDTH+1:0]     o_ext,
    output logic                              o_pos,
    output logic signed [COORD_WIDTH-1:0]     o_centre,
    output logic signed [COORD_WIDTH-1:0]     o_omin,
    output logic signed [COORD_WIDTH-1:0]     o_omax
);
    import aoc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int SW = COORD_WIDTH + 1;
    localparam int EW = COORD_WIDTH + 2;

    logic signed [CW-1:0] qmin, qmax, omin, omax;

    // A coordinate is the low COORD_WIDTH bits of its field; above the field
    // width there is nothing to sign-extend from, so the value is taken as is.
    generate
        if (CW > FIELD_W) begin : g_zext
            assign qmin = $signed({{(CW-FIELD_W){1'b0}}, i_qmin});
            assign qmax = $signed({{(CW-FIELD_W){1'b0}}, i_qmax});
            assign omin = $signed({{(CW-FIELD_W){1'b0}}, i_omin});
            assign omax = $signed({{(CW-FIELD_W){1'b0}}, i_omax});
        end else begin : g_trunc
            assign qmin = $signed(i_qmin[CW-1:0]);
            assign qmax = $signed(i_qmax[CW-1:0]);
            assign omin = $signed(i_omin[CW-1:0]);
            assign omax = $signed(i_omax[CW-1:0]);
        end
    endgenerate

    // First stage: overlap bounds and centre sums.
    logic signed [CW-1:0] n_s1_lo, n_s1_hi;
    logic signed [SW-1:0] n_s1_qsum, n_s1_osum;
    logic signed [CW-1:0] r_s1_lo, r_s1_hi, r_s1_omin, r_s1_omax;
    logic signed [SW-1:0] r_s1_qsum, r_s1_osum;

    always_comb begin
        n_s1_lo   = (qmin > omin) ? qmin : omin;
        n_s1_hi   = (qmax < omax) ? qmax : omax;
        n_s1_qsum = SW'(qmin) + SW'(qmax);
        n_s1_osum = SW'(omin) + SW'(omax);
    end

    always_ff @(posedge i_clk) begin
        r_s1_lo   <= n_s1_lo;
        r_s1_hi   <= n_s1_hi;
        r_s1_qsum <= n_s1_qsum;
        r_s1_osum <= n_s1_osum;
        r_s1_omin <= omin;
        r_s1_omax <= omax;
    end

    // Second stage: extent, normal sign and the floored query centre.
    logic signed [EW-1:0] n_s2_ext;
    logic signed [SW-1:0] centre_full;
    logic signed [EW-1:0] r_s2_ext;
    logic                 r_s2_pos;
    logic signed [CW-1:0] r_s2_centre, r_s2_omin, r_s2_omax;

    always_comb begin
        n_s2_ext    = EW'(r_s1_hi) - EW'(r_s1_lo);
        centre_full = r_s1_qsum >>> 1;
    end

    always_ff @(posedge i_clk) begin
        r_s2_ext    <= n_s2_ext;
        r_s2_pos    <= (r_s1_qsum >= r_s1_osum);
        r_s2_centre <= CW'(centre_full);
        r_s2_omin   <= r_s1_omin;
        r_s2_omax   <= r_s1_omax;
    end

    assign o_ext    = r_s2_ext;
    assign o_pos    = r_s2_pos;
    assign o_centre = r_s2_centre;
    assign o_omin   = r_s2_omin;
    assign o_omax   = r_s2_omax;

endmodule

// ===== rtl/core/aabb_overlap_contact_core.sv =====
// Box overlap and contact core.
//
// A word is offered by driving the twelve corner coordinates (query and
// obstacle boxes, min and max corners, signed Q16.16) and raising start.
// It is taken at every rising edge where start is high and busy is low;
// busy is held low, so a new box pair can enter on every clock.
//
// The result leaves on the o_ ports for exactly one cycle, marked by
// o_done: hit flag, depth, separation axis, normal sign and contact point.
// A miss gives all result fields zero. Results come out in input order.
//
// Words pass through four register stages (bounds and sums, extents and
// signs, axis pick and clamp, output). Throughput is one word per cycle,
// since no stage ever holds a word. The receiver cannot hold results off,
// and none is needed: no stage stalls.
//
// Reset (i_rst_n low at a rising edge) clears the valid bits of every stage,
// so words in flight are dropped and o_done stays low until new work arrives.
module aabb_overlap_contact_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_min_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_min_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_min_z,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_max_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_max_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_max_z,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_min_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_min_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_min_z,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_max_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_max_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_max_z,
    output logic                        o_done,
    output logic                        o_hit,
    output logic [aoc_pkg::FIELD_W-1:0] o_depth,
    output logic [1:0]                  o_sep_axis,
    output logic                        o_sep_positive,
    output logic [aoc_pkg::FIELD_W-1:0] o_contact_x,
    output logic [aoc_pkg::FIELD_W-1:0] o_contact_y,
    output logic [aoc_pkg::FIELD_W-1:0] o_contact_z
);
    import aoc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int EW = COORD_WIDTH + 2;

    logic [FIELD_W-1:0]   qmin [NUM_AXES];
    logic [FIELD_W-1:0]   qmax [NUM_AXES];
    logic [FIELD_W-1:0]   omin [NUM_AXES];
    logic [FIELD_W-1:0]   omax [NUM_AXES];
    logic signed [EW-1:0] ext  [NUM_AXES];
    logic                 pos  [NUM_AXES];
    logic signed [CW-1:0] centre [NUM_AXES];
    logic signed [CW-1:0] a_omin [NUM_AXES];
    logic signed [CW-1:0] a_omax [NUM_AXES];

    assign qmin[0] = i_query_min_x;
    assign qmin[1] = i_query_min_y;
    assign qmin[2] = i_query_min_z;
    assign qmax[0] = i_query_max_x;
    assign qmax[1] = i_query_max_y;
    assign qmax[2] = i_query_max_z;
    assign omin[0] = i_obst_min_x;
    assign omin[1] = i_obst_min_y;
    assign omin[2] = i_obst_min_z;
    assign omax[0] = i_obst_max_x;
    assign omax[1] = i_obst_max_y;
    assign omax[2] = i_obst_max_z;

    // Stages one and two run per axis.
    generate
        for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
            aoc_axis #(
                .COORD_WIDTH(COORD_WIDTH)
            ) u_axis (
                .i_clk    (i_clk),
                .i_qmin   (qmin[g]),
                .i_qmax   (qmax[g]),
                .i_omin   (omin[g]),
                .i_omax   (omax[g]),
                .o_ext    (ext[g]),
                .o_pos    (pos[g]),
                .o_centre (centre[g]),
                .o_omin   (a_omin[g]),
                .o_omax   (a_omax[g])
            );
        end
    endgenerate

    // Valid bits, one per stage, travel alongside the data.
    logic [3:0] r_vld;
    logic [3:0] n_vld;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[2:0], start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Third stage: smallest extent with ties to x then y, and the clamped
    // centre and obstacle face on every axis.
    logic                 n_s3_hit, r_s3_hit;
    t_axis                n_s3_axis, r_s3_axis;
    logic signed [EW-1:0] n_s3_depth, r_s3_depth;
    logic                 n_s3_pos, r_s3_pos;
    logic signed [CW-1:0] n_s3_face [NUM_AXES];
    logic signed [CW-1:0] r_s3_face [NUM_AXES];
    logic signed [CW-1:0] n_s3_clamp [NUM_AXES];
    logic signed [CW-1:0] r_s3_clamp [NUM_AXES];
    logic                 y_lt_x, z_lt_x, z_lt_y;

    always_comb begin
        y_lt_x   = ext[1] < ext[0];
        z_lt_x   = ext[2] < ext[0];
        z_lt_y   = ext[2] < ext[1];
        n_s3_hit = (ext[0] > 0) && (ext[1] > 0) && (ext[2] > 0);
        if (y_lt_x) begin
            n_s3_axis = z_lt_y ? AXIS_Z : AXIS_Y;
        end else begin
            n_s3_axis = z_lt_x ? AXIS_Z : AXIS_X;
        end
        case (n_s3_axis)
            AXIS_Y: begin
                n_s3_depth = ext[1];
                n_s3_pos   = pos[1];
            end
            AXIS_Z: begin
                n_s3_depth = ext[2];
                n_s3_pos   = pos[2];
            end
            default: begin
                n_s3_depth = ext[0];
                n_s3_pos   = pos[0];
            end
        endcase
        for (int k = 0; k < NUM_AXES; k++) begin
            n_s3_face[k] = pos[k] ? a_omax[k] : a_omin[k];
            // On a hit the obstacle is not inverted, so this is the clamp.
            if (centre[k] > a_omax[k]) begin
                n_s3_clamp[k] = a_omax[k];
            end else if (centre[k] < a_omin[k]) begin
                n_s3_clamp[k] = a_omin[k];
            end else begin
                n_s3_clamp[k] = centre[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_hit   <= n_s3_hit;
        r_s3_axis  <= n_s3_axis;
        r_s3_depth <= n_s3_depth;
        r_s3_pos   <= n_s3_pos;
        r_s3_face  <= n_s3_face;
        r_s3_clamp <= n_s3_clamp;
    end

    // Fourth stage: assemble the result word, all zero on a miss.
    logic               n_hit, r_hit;
    logic [FIELD_W-1:0] n_depth, r_depth;
    logic [1:0]         n_sep_axis, r_sep_axis;
    logic               n_sep_pos, r_sep_pos;
    logic [FIELD_W-1:0] n_contact [NUM_AXES];
    logic [FIELD_W-1:0] r_contact [NUM_AXES];

    always_comb begin
        n_hit      = r_s3_hit;
        n_depth    = '0;
        n_sep_axis = '0;
        n_sep_pos  = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            n_contact[k] = '0;
        end
        if (r_s3_hit) begin
            n_depth    = FIELD_W'(r_s3_depth);
            n_sep_axis = r_s3_axis;
            n_sep_pos  = r_s3_pos;
            for (int k = 0; k < NUM_AXES; k++) begin
                if (r_s3_axis == t_axis'(k)) begin
                    n_contact[k] = FIELD_W'(r_s3_face[k]);
                end else begin
                    n_contact[k] = FIELD_W'(r_s3_clamp[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_depth    <= n_depth;
        r_sep_axis <= n_sep_axis;
        r_sep_pos  <= n_sep_pos;
        r_contact  <= n_contact;
    end

    assign o_done         = r_vld[3];
    assign o_hit          = r_hit;
    assign o_depth        = r_depth;
    assign o_sep_axis     = r_sep_axis;
    assign o_sep_positive = r_sep_pos;
    assign o_contact_x    = r_contact[0];
    assign o_contact_y    = r_contact[1];
    assign o_contact_z    = r_contact[2];

endmodule

// ===== tb/aoc_contact_check.sv =====
`timescale 1ns / 100ps

module aoc_contact_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_min_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_min_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_min_z,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_max_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_max_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_query_max_z,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_min_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_min_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_min_z,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_max_x,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_max_y,
    input  logic [aoc_pkg::FIELD_W-1:0] i_obst_max_z,
    input  logic                        o_done,
    input  logic                        o_hit,
    input  logic [aoc_pkg::FIELD_W-1:0] o_depth,
    input  logic [1:0]                  o_sep_axis,
    input  logic                        o_sep_positive,
    input  logic [aoc_pkg::FIELD_W-1:0] o_contact_x,
    input  logic [aoc_pkg::FIELD_W-1:0] o_contact_y,
    input  logic [aoc_pkg::FIELD_W-1:0] o_contact_z,
    output int                          fail_count,
    output int                          words_pending
);
    import aoc_pkg::*;

    typedef logic [NUM_AXES-1:0][FIELD_W-1:0] t_corner;

    typedef struct packed {
        logic    hit;
        logic    [FIELD_W-1:0] depth;
        t_axis   axis;
        logic    positive;
        t_corner contact;
    } t_contact;

    t_contact contacts_due[$];
    t_contact want;
    t_corner  got_contact;
    int       errs = 0;

    function automatic t_contact predict_contact(input t_corner qlo, input t_corner qhi,
                                                 input t_corner olo, input t_corner ohi);
        t_contact r;
        longint   ql[NUM_AXES], qh[NUM_AXES], ol[NUM_AXES], oh[NUM_AXES], ext[NUM_AXES];
        longint   lo, hi, p, sum_diff;
        t_axis    ax;
        logic     overlap;
        r       = '0;
        overlap = 1'b1;
        for (int k = 0; k < NUM_AXES; k++) begin
            ql[k]  = longint'($signed(qlo[k]));
            qh[k]  = longint'($signed(qhi[k]));
            ol[k]  = longint'($signed(olo[k]));
            oh[k]  = longint'($signed(ohi[k]));
            lo     = (ql[k] > ol[k]) ? ql[k] : ol[k];
            hi     = (qh[k] < oh[k]) ? qh[k] : oh[k];
            ext[k] = hi - lo;
            if (ext[k] <= 0)
                overlap = 1'b0;
        end
        if (!overlap)
            return r;

        // Strict comparisons keep ties on the earlier axis.
        ax = AXIS_X;
        if (ext[AXIS_Y] < ext[ax])
            ax = AXIS_Y;
        if (ext[AXIS_Z] < ext[ax])
            ax = AXIS_Z;

        sum_diff   = (ql[ax] + qh[ax]) - (ol[ax] + oh[ax]);
        r.hit      = 1'b1;
        r.depth    = ext[ax][FIELD_W-1:0];
        r.axis     = ax;
        r.positive = (sum_diff >= 0);
        for (int k = 0; k < NUM_AXES; k++) begin
            if (k == int'(ax)) begin
                p = r.positive ? oh[k] : ol[k];
            end else begin
                // Arithmetic shift floors the halved sum towards minus infinity.
                p = (ql[k] + qh[k]) >>> 1;
                if (p > oh[k])
                    p = oh[k];
                if (p < ol[k])
                    p = ol[k];
            end
            r.contact[k] = p[FIELD_W-1:0];
        end
        return r;
    endfunction

    task automatic flag(input string what, input logic [FIELD_W-1:0] exp_v,
                        input logic [FIELD_W-1:0] act_v);
        errs++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    // Results are taken before new words so that a word and a result on the
    // same edge never pair up with each other.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (contacts_due.size() == 0) begin
                    errs++;
                    $display("%0t: result with nothing expected, got hit %b depth %h",
                             $time, o_hit, o_depth);
                end else begin
                    want        = contacts_due.pop_front();
                    got_contact = {o_contact_z, o_contact_y, o_contact_x};
                    if (o_hit !== want.hit)
                        flag("hit", FIELD_W'(want.hit), FIELD_W'(o_hit));
                    if (o_depth !== want.depth)
                        flag("depth", want.depth, o_depth);
                    if (o_sep_axis !== want.axis)
                        flag("sep_axis", FIELD_W'(want.axis), FIELD_W'(o_sep_axis));
                    if (o_sep_positive !== want.positive)
                        flag("sep_positive", FIELD_W'(want.positive),
                             FIELD_W'(o_sep_positive));
                    for (int k = 0; k < NUM_AXES; k++) begin
                        if (got_contact[k] !== want.contact[k])
                            flag($sformatf("contact[%0d]", k), want.contact[k],
                                 got_contact[k]);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                contacts_due.push_back(predict_contact(
                    {i_query_min_z, i_query_min_y, i_query_min_x},
                    {i_query_max_z, i_query_max_y, i_query_max_x},
                    {i_obst_min_z, i_obst_min_y, i_obst_min_x},
                    {i_obst_max_z, i_obst_max_y, i_obst_max_x}));
        end
        fail_count    <= errs;
        words_pending <= contacts_due.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import aoc_pkg::*;

    // Corners in order: query min xyz, query max xyz, obstacle min xyz, obstacle max xyz.
    typedef logic [4*NUM_AXES-1:0][FIELD_W-1:0] t_box_pair;

    typedef enum int {
        SPAN_TINY,
        SPAN_MID,
        SPAN_FULL,
        SPAN_EDGE
    } t_span;

    localparam int QLO = 0;
    localparam int QHI = NUM_AXES;
    localparam int OLO = 2 * NUM_AXES;
    localparam int OHI = 3 * NUM_AXES;
    localparam int RANDOM_WORDS = 1650;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_box_pair          drv;
    logic               o_done;
    logic               o_hit;
    logic [FIELD_W-1:0] o_depth;
    logic [1:0]         o_sep_axis;
    logic               o_sep_positive;
    logic [FIELD_W-1:0] o_contact_x;
    logic [FIELD_W-1:0] o_contact_y;
    logic [FIELD_W-1:0] o_contact_z;
    int                 fail_count;
    int                 words_pending;
    logic               burst;

    aabb_overlap_contact_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_query_min_x  (drv[QLO]),
        .i_query_min_y  (drv[QLO+1]),
        .i_query_min_z  (drv[QLO+2]),
        .i_query_max_x  (drv[QHI]),
        .i_query_max_y  (drv[QHI+1]),
        .i_query_max_z  (drv[QHI+2]),
        .i_obst_min_x   (drv[OLO]),
        .i_obst_min_y   (drv[OLO+1]),
        .i_obst_min_z   (drv[OLO+2]),
        .i_obst_max_x   (drv[OHI]),
        .i_obst_max_y   (drv[OHI+1]),
        .i_obst_max_z   (drv[OHI+2]),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_depth        (o_depth),
        .o_sep_axis     (o_sep_axis),
        .o_sep_positive (o_sep_positive),
        .o_contact_x    (o_contact_x),
        .o_contact_y    (o_contact_y),
        .o_contact_z    (o_contact_z)
    );

    aoc_contact_check checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_query_min_x  (drv[QLO]),
        .i_query_min_y  (drv[QLO+1]),
        .i_query_min_z  (drv[QLO+2]),
        .i_query_max_x  (drv[QHI]),
        .i_query_max_y  (drv[QHI+1]),
        .i_query_max_z  (drv[QHI+2]),
        .i_obst_min_x   (drv[OLO]),
        .i_obst_min_y   (drv[OLO+1]),
        .i_obst_min_z   (drv[OLO+2]),
        .i_obst_max_x   (drv[OHI]),
        .i_obst_max_y   (drv[OHI+1]),
        .i_obst_max_z   (drv[OHI+2]),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_depth        (o_depth),
        .o_sep_axis     (o_sep_axis),
        .o_sep_positive (o_sep_positive),
        .o_contact_x    (o_contact_x),
        .o_contact_y    (o_contact_y),
        .o_contact_z    (o_contact_z),
        .fail_count     (fail_count),
        .words_pending  (words_pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_box_pair pair_of(input int qx0, input int qy0, input int qz0,
                                          input int qx1, input int qy1, input int qz1,
                                          input int ox0, input int oy0, input int oz0,
                                          input int ox1, input int oy1, input int oz1);
        t_box_pair p;
        p[QLO] = qx0; p[QLO+1] = qy0; p[QLO+2] = qz0;
        p[QHI] = qx1; p[QHI+1] = qy1; p[QHI+2] = qz1;
        p[OLO] = ox0; p[OLO+1] = oy0; p[OLO+2] = oz0;
        p[OHI] = ox1; p[OHI+1] = oy1; p[OHI+2] = oz1;
        return p;
    endfunction

    function automatic t_box_pair noise_pair();
        t_box_pair p;
        for (int k = 0; k < 4 * NUM_AXES; k++)
            p[k] = $urandom;
        return p;
    endfunction

    function automatic t_span pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return SPAN_TINY;
        if (r < 70)
            return SPAN_MID;
        if (r < 90)
            return SPAN_FULL;
        return SPAN_EDGE;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_coord(input t_span s);
        logic [FIELD_W-1:0] rim [7];
        rim = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
        case (s)
            SPAN_TINY: return 32'($urandom_range(0, 63)) - 32'd32;
            SPAN_MID:  return ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
            SPAN_FULL: return $urandom;
            default:   return rim[$urandom_range(0, 6)];
        endcase
    endfunction

    // Most pairs are ordered intervals that overlap or nest on every axis, so
    // that hits, ties and clamping are common; the rest are touching, inverted
    // or unstructured pairs.
    function automatic t_box_pair make_pair();
        t_box_pair          p;
        t_span              item_span, s;
        logic [FIELD_W-1:0] v [4];
        logic [FIELD_W-1:0] t, alo, ahi, blo, bhi;
        int                 kind, ax;
        item_span = pick_span();
        for (int a = 0; a < NUM_AXES; a++) begin
            s = ($urandom_range(0, 9) < 7) ? item_span : pick_span();
            for (int k = 0; k < 4; k++)
                v[k] = pick_coord(s);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3 - i; j++)
                    if ($signed(v[j]) > $signed(v[j+1])) begin
                        t = v[j]; v[j] = v[j+1]; v[j+1] = t;
                    end
            if ($urandom_range(0, 1)) begin
                alo = v[0]; ahi = v[2]; blo = v[1]; bhi = v[3];
            end else begin
                alo = v[0]; ahi = v[3]; blo = v[1]; bhi = v[2];
            end
            if ($urandom_range(0, 1)) begin
                p[QLO+a] = alo; p[QHI+a] = ahi; p[OLO+a] = blo; p[OHI+a] = bhi;
            end else begin
                p[QLO+a] = blo; p[QHI+a] = bhi; p[OLO+a] = alo; p[OHI+a] = ahi;
            end
        end
        kind = $urandom_range(0, 99);
        ax   = $urandom_range(0, NUM_AXES - 1);
        if (kind < 8) begin
            p = noise_pair();
        end else if (kind < 18) begin
            if ($urandom_range(0, 1))
                p[QLO+ax] = p[OHI+ax];
            else
                p[QHI+ax] = p[OLO+ax];
        end else if (kind < 25) begin
            if ($urandom_range(0, 1)) begin
                t = p[QLO+ax]; p[QLO+ax] = p[QHI+ax]; p[QHI+ax] = t;
            end else begin
                t = p[OLO+ax]; p[OLO+ax] = p[OHI+ax]; p[OHI+ax] = t;
            end
        end
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Holds the word until it is taken, then optionally idles with junk on
    // the coordinate ports, which must be ignored while start is low.
    task automatic offer_pair(input t_box_pair p, input int gap);
        drv   <= p;
        start <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            drv   <= noise_pair();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        start   <= 1'b0;
        drv     <= '0;
        i_rst_n <= 1'b0;
        burst   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Three-way tie, y smallest, z smallest, y and z tied.
        offer_pair(pair_of(0, 0, 0, 4, 4, 4, 2, 2, 2, 6, 6, 6), pick_gap());
        offer_pair(pair_of(0, 0, 0, 10, 4, 10, 2, 2, 2, 6, 6, 6), pick_gap());
        offer_pair(pair_of(0, 0, 0, 10, 10, 3, 1, 1, 1, 9, 9, 9), pick_gap());
        offer_pair(pair_of(0, 0, 0, 10, 3, 3, 1, 1, 1, 9, 9, 9), pick_gap());
        // Equal centres count as positive; then a clearly positive normal.
        offer_pair(pair_of(2, 2, 2, 4, 4, 4, 0, 0, 0, 6, 6, 6), pick_gap());
        offer_pair(pair_of(4, 0, 0, 8, 9, 9, 0, 0, 0, 6, 10, 10), pick_gap());
        // Touching faces and inverted boxes never hit.
        offer_pair(pair_of(0, 0, 0, 4, 4, 4, 4, 0, 0, 8, 4, 4), pick_gap());
        offer_pair(pair_of(0, 0, 0, 4, 4, 4, 0, 0, -4, 4, 4, 0), pick_gap());
        offer_pair(pair_of(5, 0, 0, 1, 4, 4, 0, 0, 0, 6, 4, 4), pick_gap());
        offer_pair(pair_of(0, 0, 0, 6, 6, 6, 0, 5, 0, 6, 1, 6), pick_gap());
        // Odd negative sums round down; a centre is clamped to the obstacle minimum.
        offer_pair(pair_of(-3, -7, -100, 0, 0, -99, -10, -10, -100, 10, 10, 10), pick_gap());
        offer_pair(pair_of(-20, 30, 0, -1, 40, 3, -5, 0, 0, 50, 35, 10), pick_gap());
        // Full-range boxes and thin slabs at both ends of the range.
        offer_pair(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), pick_gap());
        offer_pair(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0001, 32'h8000_0001, 32'h8000_0001), pick_gap());
        offer_pair(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFE,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), pick_gap());
        offer_pair('0, pick_gap());
        offer_pair('1, pick_gap());
        offer_pair(pair_of(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                           32'hD555_5555, 32'hD555_5555, 32'hD555_5555,
                           32'h2AAA_AAAA, 32'h2AAA_AAAA, 32'h2AAA_AAAA), pick_gap());
        offer_pair(pair_of(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                           32'h0003_8000, 32'h0004_0000, 32'h0001_0000,
                           32'h0002_0000, 32'h0001_0000, 32'hFFFE_0000,
                           32'h0005_0000, 32'h0003_0000, 32'h0000_4000), pick_gap());

        // The sender holds off until every result so far has come back.
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 150 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_WORDS / 2)
                drain();
            offer_pair(make_pair(), burst ? 0 : pick_gap());
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
